/* sv/bpt_pkg.sv */
// bpt_pkg: shared types, constants and helpers for the pressure/temperature compensation
// pipeline; used by bpt_scale, bpt_mulq and the top level under sv/, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package bpt_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_CAL_LO  = 3'd0,
		CFG_CAL_MID = 3'd1,
		CFG_CAL_HI  = 3'd2,
		CFG_P_OSR   = 3'd3,
		CFG_T_OSR   = 3'd4
	} cfg_idx_t;

	// oversampling divisors, index 0 = single to 7 = 128 times
	localparam logic [23:0] OSR_DIV [8] = '{
		24'd524288, 24'd1572864, 24'd3670016, 24'd7864320,
		24'd253952, 24'd516096, 24'd1040384, 24'd2088960
	};

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] ADD_POS_LIM = 65'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] ADD_NEG_LIM = 65'sh1_8000_0000_0000_0001;

	// saturated value with its clip flag
	typedef struct packed {
		logic              clip;
		logic signed [63:0] val;
	} sat_t;

	// add saturating symmetrically to +-(2^63 - 1)
	function automatic sat_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
		logic signed [64:0] s;
		sat_t r;
		s = 65'(a) + 65'(b);
		if (s > ADD_POS_LIM) begin
			r.clip = 1'b1;
			r.val = S64_MAX;
		end else if (s < ADD_NEG_LIM) begin
			r.clip = 1'b1;
			r.val = -S64_MAX;
		end else begin
			r.clip = 1'b0;
			r.val = s[63:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/bpt_dly.sv */
// bpt_dly: fixed-length register delay line with a shared advance enable
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module bpt_dly #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] d,
	output logic      [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	// shift one place on each advance
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

`default_nettype wire

/* sv/bpt_scale.sv */
// bpt_scale: raw 24-bit code times reciprocal of the oversampling divisor, three stages
// depends on bpt_pkg (divisor table)
`timescale 1ns / 1ps
`default_nettype none

module bpt_scale
	import bpt_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [23:0]        raw,
	input  wire logic [2:0]         osr,
	output logic signed [63:0]      x
);

	localparam logic [63:0] ONE_EXT = 64'd1 << (FRAC_BITS + 24);
	localparam logic [47:0] RECIP [8] = '{
		48'((ONE_EXT + 64'(OSR_DIV[0] / 2)) / 64'(OSR_DIV[0])),
		48'((ONE_EXT + 64'(OSR_DIV[1] / 2)) / 64'(OSR_DIV[1])),
		48'((ONE_EXT + 64'(OSR_DIV[2] / 2)) / 64'(OSR_DIV[2])),
		48'((ONE_EXT + 64'(OSR_DIV[3] / 2)) / 64'(OSR_DIV[3])),
		48'((ONE_EXT + 64'(OSR_DIV[4] / 2)) / 64'(OSR_DIV[4])),
		48'((ONE_EXT + 64'(OSR_DIV[5] / 2)) / 64'(OSR_DIV[5])),
		48'((ONE_EXT + 64'(OSR_DIV[6] / 2)) / 64'(OSR_DIV[6])),
		48'((ONE_EXT + 64'(OSR_DIV[7] / 2)) / 64'(OSR_DIV[7]))
	};

	logic [23:0] mag_s1;
	logic        neg_s1;
	logic [47:0] rcp_s1;
	logic [47:0] plo_s2;
	logic [47:0] phi_s2;
	logic        neg_s2;
	logic [71:0] full;
	logic [63:0] rnd;

	// magnitude and reciprocal select
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= raw[23];
			mag_s1 <= raw[23] ? 24'(-raw) : raw;
			rcp_s1 <= RECIP[osr];
		end
	end

	// two 24x24 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			plo_s2 <= mag_s1 * rcp_s1[23:0];
			phi_s2 <= mag_s1 * rcp_s1[47:24];
			neg_s2 <= neg_s1;
		end
	end

	// combine, round half away and restore sign
	always_comb begin
		full = 72'(plo_s2) + {phi_s2, 24'd0};
		rnd = 64'((full + 72'(24'h80_0000)) >> 24);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x <= neg_s2 ? -$signed(rnd) : $signed(rnd);
		end
	end

endmodule

`default_nettype wire

/* sv/bpt_mulq.sv */
// bpt_mulq: saturating fixed-point product round(a*b / 2^F), four stages
// depends on bpt_pkg (saturation limit)
`timescale 1ns / 1ps
`default_nettype none

module bpt_mulq
	import bpt_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	output logic signed [63:0]      p,
	output logic                    clip
);

	localparam logic [127:0] HALF = 128'd1 << (FRAC_BITS - 1);

	logic [63:0]  ua_s1;
	logic [63:0]  ub_s1;
	logic         neg_s1;
	logic [63:0]  pp00_s2;
	logic [63:0]  pp01_s2;
	logic [63:0]  pp10_s2;
	logic [63:0]  pp11_s2;
	logic         neg_s2;
	logic [127:0] prod;
	logic [62:0]  res_s3;
	logic         ovf_s3;
	logic         neg_s3;

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1 <= a[63] ? 64'(-a) : 64'(a);
			ub_s1 <= b[63] ? 64'(-b) : 64'(b);
			neg_s1 <= a[63] ^ b[63];
		end
	end

	// 32x32 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s2 <= ua_s1[31:0] * ub_s1[31:0];
			pp01_s2 <= ua_s1[31:0] * ub_s1[63:32];
			pp10_s2 <= ua_s1[63:32] * ub_s1[31:0];
			pp11_s2 <= ua_s1[63:32] * ub_s1[63:32];
			neg_s2 <= neg_s1;
		end
	end

	// sum with rounding offset, overflow past 2^63 - 1 after the shift
	always_comb begin
		prod = {64'd0, pp00_s2} + {32'd0, pp01_s2, 32'd0} + {32'd0, pp10_s2, 32'd0}
			+ {pp11_s2, 64'd0} + HALF;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s3 <= |prod[127:63+FRAC_BITS];
			res_s3 <= prod[62+FRAC_BITS:FRAC_BITS];
			neg_s3 <= neg_s2;
		end
	end

	// saturate and sign
	always_ff @(posedge clk) begin
		if (en) begin
			clip <= ovf_s3;
			if (ovf_s3) begin
				p <= neg_s3 ? -S64_MAX : S64_MAX;
			end else begin
				p <= neg_s3 ? -$signed({1'b0, res_s3}) : $signed({1'b0, res_s3});
			end
		end
	end

endmodule

`default_nettype wire

/* sv/baro_pressure_temp_compensation.sv */
// baro_pressure_temp_compensation: top level of the compensation pipeline
// depends on bpt_pkg, bpt_dly, bpt_scale, bpt_mulq
//
//  channel   direction  handshake            word
//  in        sink       in_valid / in_stall  raw_pressure_bits, raw_temperature_bits
//  out       source     out_valid/out_stall  temperature_q8, pressure_q4, clipped
//  cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word in per cycle while the output is not stalled; the pipeline depth is set
// by the pressure polynomial: scaling, then three chained products and five sums
// reset clears valid bits and configuration (oversampling to 4 and 1)
// a stall on a valid output freezes the whole pipeline; in_stall follows it
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_temp_compensation
	import bpt_pkg::*;
#(
	parameter int SCALED_FRACTION_BITS = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [23:0]        raw_pressure_bits,
	input  wire logic [23:0]        raw_temperature_bits,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      temperature_q8,
	output logic signed [39:0]      pressure_q4,
	output logic                    clipped,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [47:0]        cfg_data
);

	localparam int F = SCALED_FRACTION_BITS;
	localparam int NSTAGE = 21;

	logic [47:0] cal_lo_q;
	logic [47:0] cal_mid_q;
	logic [47:0] cal_hi_q;
	logic [2:0]  p_osr_q;
	logic [2:0]  t_osr_q;

	logic [NSTAGE-1:0] vld_q;
	logic              pipe_en;

	logic signed [63:0] c0h, c1s, c00s, c10s, c01s, c11s, c20s, c21s, c30s;
	logic signed [63:0] psc, tsc, psc_d5, psc_d10;
	logic signed [63:0] pa, pb, pe, pf, pg, pc, ph, pd, pe_d, ph_d, temp_d;
	logic               ka, kb, ke, kf, kg, kc, kh, kd;
	sat_t               temp_s8, inner1_s8, inner3_s8, inner2_s13;
	sat_t               pres1_s18, pres2_s19, pres3_s20;
	logic signed [63:0] tp_s8;
	logic               clip_s8, clip_s13, clip_s18, clip_s19, clip_s20;
	logic               clip8_d, clip13_d;

	logic [63:0] t_mag, t_rnd, p_mag, p_rnd;
	logic        t_neg, p_neg;
	logic signed [31:0] tq8;
	logic signed [39:0] pq4;
	logic        t_clip, p_clip;
	logic signed [31:0] tq8_s21;
	logic signed [39:0] pq4_s21;
	logic        clip_s21;

	// configuration writes, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_lo_q <= '0;
			cal_mid_q <= '0;
			cal_hi_q <= '0;
			p_osr_q <= 3'd4;
			t_osr_q <= 3'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CAL_LO:  cal_lo_q <= cfg_data;
				CFG_CAL_MID: cal_mid_q <= cfg_data;
				CFG_CAL_HI:  cal_hi_q <= cfg_data;
				CFG_P_OSR:   p_osr_q <= cfg_data[2:0];
				CFG_T_OSR:   t_osr_q <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// coefficient unpack, scaled to Q(F)
	always_comb begin
		c0h  = 64'($signed(cal_lo_q[47:36])) <<< (F - 1);
		c1s  = 64'($signed(cal_lo_q[35:24])) <<< F;
		c00s = 64'($signed(cal_lo_q[23:4])) <<< F;
		c10s = 64'($signed({cal_lo_q[3:0], cal_mid_q[47:32]})) <<< F;
		c01s = 64'($signed(cal_mid_q[31:16])) <<< F;
		c11s = 64'($signed(cal_mid_q[15:0])) <<< F;
		c20s = 64'($signed(cal_hi_q[47:32])) <<< F;
		c21s = 64'($signed(cal_hi_q[31:16])) <<< F;
		c30s = 64'($signed(cal_hi_q[15:0])) <<< F;
	end

	// pipeline advance and valid bits
	assign in_stall = vld_q[NSTAGE-1] & out_stall;
	assign pipe_en = ~in_stall;
	assign out_valid = vld_q[NSTAGE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[NSTAGE-2:0], in_valid};
		end
	end

	// stages 1 to 3: scaled raw codes
	bpt_scale #(.FRAC_BITS(F)) u_scale_p (
		.clk(clk), .en(pipe_en), .raw(raw_pressure_bits), .osr(p_osr_q), .x(psc)
	);
	bpt_scale #(.FRAC_BITS(F)) u_scale_t (
		.clk(clk), .en(pipe_en), .raw(raw_temperature_bits), .osr(t_osr_q), .x(tsc)
	);

	// stages 4 to 7: independent first products
	bpt_mulq #(.FRAC_BITS(F)) u_mul_a (
		.clk(clk), .en(pipe_en), .a(tsc), .b(c1s), .p(pa), .clip(ka)
	);
	bpt_mulq #(.FRAC_BITS(F)) u_mul_b (
		.clk(clk), .en(pipe_en), .a(psc), .b(c30s), .p(pb), .clip(kb)
	);
	bpt_mulq #(.FRAC_BITS(F)) u_mul_e (
		.clk(clk), .en(pipe_en), .a(tsc), .b(c01s), .p(pe), .clip(ke)
	);
	bpt_mulq #(.FRAC_BITS(F)) u_mul_f (
		.clk(clk), .en(pipe_en), .a(tsc), .b(psc), .p(pf), .clip(kf)
	);
	bpt_mulq #(.FRAC_BITS(F)) u_mul_g (
		.clk(clk), .en(pipe_en), .a(psc), .b(c21s), .p(pg), .clip(kg)
	);

	// stage 8: temperature and inner sums
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			temp_s8 <= sat_add(c0h, pa);
			inner1_s8 <= sat_add(c20s, pb);
			inner3_s8 <= sat_add(c11s, pg);
			tp_s8 <= pf;
			clip_s8 <= ka | kb | ke | kf | kg;
		end
	end

	bpt_dly #(.WIDTH(64), .DEPTH(5)) u_dly_psc5 (
		.clk(clk), .en(pipe_en), .d(psc), .q(psc_d5)
	);
	bpt_dly #(.WIDTH(64), .DEPTH(10)) u_dly_psc10 (
		.clk(clk), .en(pipe_en), .d(psc), .q(psc_d10)
	);

	// stages 9 to 12: second products
	bpt_mulq #(.FRAC_BITS(F)) u_mul_c (
		.clk(clk), .en(pipe_en), .a(psc_d5), .b(inner1_s8.val), .p(pc), .clip(kc)
	);
	bpt_mulq #(.FRAC_BITS(F)) u_mul_h (
		.clk(clk), .en(pipe_en), .a(tp_s8), .b(inner3_s8.val), .p(ph), .clip(kh)
	);

	bpt_dly #(.WIDTH(1), .DEPTH(4)) u_dly_clip8 (
		.clk(clk), .en(pipe_en),
		.d(clip_s8 | temp_s8.clip | inner1_s8.clip | inner3_s8.clip), .q(clip8_d)
	);

	// stage 13: second inner sum
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			inner2_s13 <= sat_add(c10s, pc);
			clip_s13 <= clip8_d | kc | kh;
		end
	end

	// stages 14 to 17: last pressure product
	bpt_mulq #(.FRAC_BITS(F)) u_mul_d (
		.clk(clk), .en(pipe_en), .a(psc_d10), .b(inner2_s13.val), .p(pd), .clip(kd)
	);

	bpt_dly #(.WIDTH(1), .DEPTH(4)) u_dly_clip13 (
		.clk(clk), .en(pipe_en), .d(clip_s13 | inner2_s13.clip), .q(clip13_d)
	);
	bpt_dly #(.WIDTH(64), .DEPTH(11)) u_dly_e (
		.clk(clk), .en(pipe_en), .d(pe), .q(pe_d)
	);
	bpt_dly #(.WIDTH(64), .DEPTH(7)) u_dly_h (
		.clk(clk), .en(pipe_en), .d(ph), .q(ph_d)
	);
	bpt_dly #(.WIDTH(64), .DEPTH(12)) u_dly_temp (
		.clk(clk), .en(pipe_en), .d(temp_s8.val), .q(temp_d)
	);

	// stages 18 to 20: pressure sums in order
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pres1_s18 <= sat_add(c00s, pd);
			clip_s18 <= clip13_d | kd;
			pres2_s19 <= sat_add(pres1_s18.val, pe_d);
			clip_s19 <= clip_s18 | pres1_s18.clip;
			pres3_s20 <= sat_add(pres2_s19.val, ph_d);
			clip_s20 <= clip_s19 | pres2_s19.clip;
		end
	end

	// output rounding and range clamp
	always_comb begin
		t_neg = temp_d[63];
		t_mag = t_neg ? 64'(-temp_d) : 64'(temp_d);
		t_rnd = (t_mag + (64'd1 << (F - 9))) >> (F - 8);
		t_clip = t_neg ? (t_rnd > 64'h8000_0000) : (t_rnd > 64'h7FFF_FFFF);
		if (t_clip) begin
			tq8 = t_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			tq8 = t_neg ? -$signed(t_rnd[31:0]) : $signed(t_rnd[31:0]);
		end
		p_neg = pres3_s20.val[63];
		p_mag = p_neg ? 64'(-pres3_s20.val) : 64'(pres3_s20.val);
		p_rnd = (p_mag + (64'd1 << (F - 5))) >> (F - 4);
		p_clip = p_neg ? (p_rnd > 64'h80_0000_0000) : (p_rnd > 64'h7F_FFFF_FFFF);
		if (p_clip) begin
			pq4 = p_neg ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
		end else begin
			pq4 = p_neg ? -$signed(p_rnd[39:0]) : $signed(p_rnd[39:0]);
		end
	end

	// stage 21: output register
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			tq8_s21 <= tq8;
			pq4_s21 <= pq4;
			clip_s21 <= clip_s20 | pres3_s20.clip | t_clip | p_clip;
		end
	end

	assign temperature_q8 = tq8_s21;
	assign pressure_q4 = pq4_s21;
	assign clipped = clip_s21;

	// pipeline checks
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(vld_q))
		else $error("valid bits moved while the pipeline was stalled");

	a_entry_tracks_input: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_en |=> vld_q[0] == $past(in_valid))
		else $error("first stage valid does not follow the input");

	a_last_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_en && vld_q[NSTAGE-2] |=> out_valid)
		else $error("word lost before the output register");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no waiting result");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// tb: self-checking bench for the pressure/temperature compensation pipeline
// depends on bpt_pkg and baro_pressure_temp_compensation; carries its own fixed-point predictor
`timescale 1ns / 1ps

module tb;
	import bpt_pkg::*;

	localparam int FRAC = 24;
	localparam logic [2:0] CFG_NONE_5 = 3'd5;
	localparam logic [2:0] CFG_NONE_7 = 3'd7;
	localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] OS_DIVISOR [8] = '{
		64'd524288, 64'd1572864, 64'd3670016, 64'd7864320,
		64'd253952, 64'd516096, 64'd1040384, 64'd2088960
	};

	// expected result word
	typedef struct {
		logic signed [31:0] t_q8;
		logic signed [39:0] p_q4;
		logic               clip;
	} comp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [23:0] raw_pressure_bits = '0;
	logic [23:0] raw_temperature_bits = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] temperature_q8;
	logic signed [39:0] pressure_q4;
	logic clipped;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [47:0] cfg_data = '0;

	// shadow copy of the configuration
	logic [47:0] cal_lo, cal_mid, cal_hi;
	logic [2:0] p_os, t_os;

	comp_word_t compensated_q[$];
	int mismatches = 0;
	bit steady = 1'b0;
	int stall_left = 0;

	baro_pressure_temp_compensation uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.raw_pressure_bits(raw_pressure_bits), .raw_temperature_bits(raw_temperature_bits),
		.out_valid(out_valid), .out_stall(out_stall),
		.temperature_q8(temperature_q8), .pressure_q4(pressure_q4), .clipped(clipped),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// fixed-point helpers
	function automatic logic signed [63:0] prod_q(input logic signed [63:0] a,
			input logic signed [63:0] b, inout logic clip);
		logic [127:0] ua, ub, p, q;
		logic neg;
		ua = {64'd0, a[63] ? -a : a};
		ub = {64'd0, b[63] ? -b : b};
		neg = a[63] ^ b[63];
		p = ua * ub;
		q = (p + (128'd1 << (FRAC - 1))) >> FRAC;
		if (q > {64'd0, MAG_MAX}) begin
			clip = 1'b1;
			q = {64'd0, MAG_MAX};
		end
		return neg ? -q[63:0] : q[63:0];
	endfunction

	function automatic logic signed [63:0] sum_sat(input logic signed [63:0] a,
			input logic signed [63:0] b, inout logic clip);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > $signed({1'b0, MAG_MAX})) begin
			clip = 1'b1;
			return MAG_MAX;
		end
		if (s < -$signed({1'b0, MAG_MAX})) begin
			clip = 1'b1;
			return -MAG_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] shift_round(input logic signed [63:0] v, input int s);
		logic [63:0] m;
		m = v[63] ? -v : v;
		m = (m + (64'd1 << (s - 1))) >> s;
		return v[63] ? -m : m;
	endfunction

	function automatic logic signed [63:0] scaled_code(input logic [23:0] raw, input logic [2:0] os);
		logic [63:0] k, recip, m;
		k = OS_DIVISOR[os];
		recip = ((64'd1 << (FRAC + 24)) + k / 2) / k;
		m = {40'd0, raw[23] ? -raw : raw};
		m = (m * recip + (64'd1 << 23)) >> 24;
		return raw[23] ? -m : m;
	endfunction

	// full compensation of one sample
	function automatic comp_word_t compensate(input logic [23:0] praw, input logic [23:0] traw);
		logic [143:0] cal;
		logic signed [63:0] c0, c1, c00, c10, c01, c11, c20, c21, c30;
		logic signed [63:0] psc, tsc, tdeg, pres, acc, tp, tr, pr, pm;
		logic clip;
		comp_word_t w;
		cal = {cal_lo, cal_mid, cal_hi};
		c0 = 64'($signed(cal[143 -: 12]));
		c1 = 64'($signed(cal[131 -: 12]));
		c00 = 64'($signed(cal[119 -: 20]));
		c10 = 64'($signed(cal[99 -: 20]));
		c01 = 64'($signed(cal[79 -: 16]));
		c11 = 64'($signed(cal[63 -: 16]));
		c20 = 64'($signed(cal[47 -: 16]));
		c21 = 64'($signed(cal[31 -: 16]));
		c30 = 64'($signed(cal[15 -: 16]));
		clip = 1'b0;
		psc = scaled_code(praw, p_os);
		tsc = scaled_code(traw, t_os);
		// each product taken on its own so the clip flag is carried in order
		pm = prod_q(tsc, c1 <<< FRAC, clip);
		tdeg = sum_sat(c0 <<< (FRAC - 1), pm, clip);
		pm = prod_q(psc, c30 <<< FRAC, clip);
		acc = sum_sat(c20 <<< FRAC, pm, clip);
		pm = prod_q(psc, acc, clip);
		acc = sum_sat(c10 <<< FRAC, pm, clip);
		pm = prod_q(psc, acc, clip);
		pres = sum_sat(c00 <<< FRAC, pm, clip);
		pm = prod_q(tsc, c01 <<< FRAC, clip);
		pres = sum_sat(pres, pm, clip);
		tp = prod_q(tsc, psc, clip);
		pm = prod_q(psc, c21 <<< FRAC, clip);
		acc = sum_sat(c11 <<< FRAC, pm, clip);
		pm = prod_q(tp, acc, clip);
		pres = sum_sat(pres, pm, clip);
		tr = shift_round(tdeg, FRAC - 8);
		pr = shift_round(pres, FRAC - 4);
		// clamp to the output widths
		if (tr > 64'sd2147483647) begin
			clip = 1'b1;
			tr = 64'sd2147483647;
		end else if (tr < -64'sd2147483648) begin
			clip = 1'b1;
			tr = -64'sd2147483648;
		end
		if (pr > 64'sd549755813887) begin
			clip = 1'b1;
			pr = 64'sd549755813887;
		end else if (pr < -64'sd549755813888) begin
			clip = 1'b1;
			pr = -64'sd549755813888;
		end
		w.t_q8 = tr[31:0];
		w.p_q4 = pr[39:0];
		w.clip = clip;
		return w;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// output side: stall at random and check every accepted word
	always @(posedge clk) begin
		comp_word_t w;
		if (out_valid && !out_stall) begin
			if (compensated_q.size() == 0) begin
				report("unexpected word", 0, 0);
			end else begin
				w = compensated_q.pop_front();
				if (temperature_q8 !== w.t_q8) report("temperature_q8", temperature_q8, w.t_q8);
				if (pressure_q4 !== w.p_q4) report("pressure_q4", pressure_q4, w.p_q4);
				if (clipped !== w.clip) report("clipped", clipped, w.clip);
			end
			stall_left = steady ? 0 : $urandom_range(0, 9);
			out_stall <= (stall_left != 0);
		end else begin
			if (stall_left != 0) stall_left--;
			out_stall <= (stall_left != 0);
		end
	end

	// send one sample, leaving valid high when the next follows at once
	task automatic send_sample(input logic [23:0] praw, input logic [23:0] traw);
		int gap;
		logic taken;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure_bits <= praw;
		raw_temperature_bits <= traw;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		compensated_q.push_back(compensate(praw, traw));
	endtask

	// drop valid and let the pipeline drain
	task automatic drain;
		in_valid <= 1'b0;
		wait (compensated_q.size() == 0);
		repeat (30) @(posedge clk);
	endtask

	// one register write; valid is dropped again before the task returns
	task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
		logic done;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			done = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_CAL_LO: cal_lo = data;
			CFG_CAL_MID: cal_mid = data;
			CFG_CAL_HI: cal_hi = data;
			CFG_P_OSR: p_os = data[2:0];
			CFG_T_OSR: t_os = data[2:0];
			default: ;
		endcase
	endtask

	task automatic load_calibration(input logic [47:0] lo, input logic [47:0] mid,
			input logic [47:0] hi, input logic [2:0] pos, input logic [2:0] tos);
		write_reg(CFG_CAL_LO, lo);
		write_reg(CFG_CAL_MID, mid);
		write_reg(CFG_CAL_HI, hi);
		write_reg(CFG_P_OSR, {45'd0, pos});
		write_reg(CFG_T_OSR, {45'd0, tos});
	endtask

	function automatic logic [47:0] rand48;
		return 48'({$urandom(), $urandom()});
	endfunction

	// reset values: zero calibration, default oversampling
	task automatic test_reset_state;
		send_sample(24'h123456, 24'h654321);
		send_sample(24'h800000, 24'h7FFFFF);
		drain();
	endtask

	// code extremes against a typical calibration
	task automatic test_code_extremes;
		logic [23:0] codes [6];
		codes = '{24'h000000, 24'h000001, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'hA5A5A5};
		load_calibration(48'h0C8F_F011_A2B7, 48'hE0F4_1A2C_F3A8, 48'h0B3C_0045_FD12, 3'd4, 3'd1);
		foreach (codes[i]) send_sample(codes[i], codes[5 - i]);
		drain();
	endtask

	// coefficient extremes drive internal and output saturation; stray indexes are dropped
	task automatic test_saturation;
		load_calibration(48'h7FF7_FF7F_FFF7, 48'hFFFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 3'd0, 3'd0);
		write_reg(CFG_NONE_5, 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_NONE_7, 48'd0);
		send_sample(24'h7FFFFF, 24'h7FFFFF);
		send_sample(24'h800000, 24'h800000);
		send_sample(24'h7FFFFF, 24'h800000);
		drain();
		load_calibration(48'h8008_0080_0008, 48'h0000_8000_8000, 48'h8000_8000_8000, 3'd4, 3'd4);
		send_sample(24'h7FFFFF, 24'h800000);
		send_sample(24'h800000, 24'h7FFFFF);
		drain();
	endtask

	// every oversampling index on both channels
	task automatic test_oversampling;
		for (int i = 0; i < 8; i++) begin
			write_reg(CFG_P_OSR, 48'(i));
			write_reg(CFG_T_OSR, 48'(7 - i));
			send_sample(24'(($urandom() & 24'hFFFFFF)), 24'(($urandom() & 24'hFFFFFF)));
			drain();
		end
	endtask

	// random calibrations and samples, with phases of back-to-back traffic
	task automatic test_random;
		for (int ph = 0; ph < 11; ph++) begin
			steady = (ph % 4 == 2);
			load_calibration(rand48(), rand48(), rand48(),
				3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
			repeat (150) send_sample(24'($urandom()), 24'($urandom()));
			drain();
		end
		steady = 1'b0;
	endtask

	initial begin
		cal_lo = '0;
		cal_mid = '0;
		cal_hi = '0;
		p_os = 3'd4;
		t_os = 3'd1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (40) @(posedge clk);
		test_reset_state();
		test_code_extremes();
		test_saturation();
		test_oversampling();
		test_random();
		if (mismatches == 0 && compensated_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog
	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
